/* rtl/p1crc_pkg.sv */
// Package for the P1 telegram CRC checker: status codes, limits, the
// result struct passed from the parser, and the CRC-16 / hex digit helpers.
// No dependencies.
`timescale 1ns / 1ps

package p1crc_pkg;

   // Longest telegram body, '/' through '!' inclusive
   localparam int MAX_TELEGRAM_BYTES = 2048;
   localparam int CNT_W = $clog2(MAX_TELEGRAM_BYTES + 1);

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_MISMATCH  = 3'd1;
   localparam logic [2:0] ST_NONE      = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_NO_DIGITS = 3'd4;

   // Framing characters
   localparam logic [7:0] CHAR_START = 8'h2F;   // '/'
   localparam logic [7:0] CHAR_END   = 8'h21;   // '!'

   // Reflected CRC-16 polynomial
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic        valid;
      logic [2:0]  status;
      logic [15:0] computed_crc;
      logic [15:0] received_crc;
      logic [11:0] telegram_length;
   } result_type;

   // One byte through the reflected CRC, LSB first
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [7:0] v;
      v = 8'h00;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = b - 8'h30;
         return {1'b1, v[3:0]};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = b - 8'h37;
         return {1'b1, v[3:0]};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = b - 8'h57;
         return {1'b1, v[3:0]};
      end
      return 5'b0_0000;
   endfunction

endpackage

/* rtl/p1_telegram_crc_checker.sv */
// Top level of the P1 telegram CRC checker: request and result registers,
// check_enable register and the parser. Uses p1crc_pkg and p1crc_parser.
`timescale 1ns / 1ps

// How to use:
//  - Request channel (req_valid / req_stall): one received byte per request,
//    req_burst_end marks the last byte of a serial burst.
//  - Result channel (rsp_valid / rsp_stall): one status per telegram, with
//    the computed CRC, the received CRC field and the telegram length.
//  - CSR channel (csr_valid / csr_ready / csr_check_enable): writes the
//    check_enable bit. csr_ready is always high. Write only while idle.
//  - Throughput: one byte per cycle unless a held result is stalled. The byte
//    is registered, then the CRC update and framing logic run combinationally
//    into the result register. A result appears on rsp_* from the result
//    register, after its request has passed the request register.
//  - Stalls: while a result is held in the output register and the receiver
//    stalls, a waiting request byte is held and req_stall goes high. Bytes
//    that produce no result still advance as long as nothing is held.
//  - Reset: synchronous, active high. Clears the pipeline, returns the
//    parser to hunting for '/', and sets check_enable to 1.
module p1_telegram_crc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_burst_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_computed_crc,
   output logic [15:0] rsp_received_crc,
   output logic [11:0] rsp_telegram_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_check_enable
);

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_end_ff;
   logic                  check_enable_ff;
   logic                  out_valid_ff, out_valid_in;
   p1crc_pkg::result_type out_ff;
   p1crc_pkg::result_type parse_result;
   logic                  out_blocked;
   logic                  step;

   assign out_blocked = out_valid_ff && rsp_stall;
   assign step        = in_valid_ff && !out_blocked;
   assign req_stall   = in_valid_ff && out_blocked;
   assign csr_ready   = 1'b1;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         check_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         check_enable_ff <= csr_check_enable;
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_burst_end;
      end
   end

   p1crc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .burst_end    (in_end_ff),
      .check_enable (check_enable_ff),
      .result       (parse_result)
   );

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (step && parse_result.valid) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && parse_result.valid) begin
         out_ff <= parse_result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_computed_crc    = out_ff.computed_crc;
   assign rsp_received_crc    = out_ff.received_crc;
   assign rsp_telegram_length = out_ff.telegram_length;

   // Checks
   a_no_telegram_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == p1crc_pkg::ST_NONE) |->
         (rsp_computed_crc == 16'h0000 && rsp_received_crc == 16'h0000 &&
          rsp_telegram_length == 12'h000))
      else $error("no-telegram status carries nonzero fields");

   a_too_long_no_field: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == p1crc_pkg::ST_TOO_LONG) |->
         (rsp_received_crc == 16'h0000))
      else $error("too-long status carries a received CRC");

   a_check_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !check_enable_ff) |->
         (rsp_status != p1crc_pkg::ST_MISMATCH &&
          rsp_status != p1crc_pkg::ST_NO_DIGITS))
      else $error("CRC failure reported with checking disabled");

   a_ok_matches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && check_enable_ff && rsp_status == p1crc_pkg::ST_OK) |->
         (rsp_computed_crc == rsp_received_crc))
      else $error("ok status with differing CRCs");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && $past(rsp_valid) == 1'b1 || rsp_valid))
      else $error("request stalled without a held result");

endmodule

/* rtl/p1crc_parser.sv */
// Telegram parser: framing state, running CRC, byte counter and CRC digit
// collection. Produces at most one result per byte. Uses p1crc_pkg.
`timescale 1ns / 1ps

module p1crc_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   burst_end,
   input  logic                   check_enable,
   output p1crc_pkg::result_type  result
);

   localparam logic [1:0] PH_HUNT   = 2'd0;
   localparam logic [1:0] PH_BODY   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   localparam int CW = p1crc_pkg::CNT_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(p1crc_pkg::MAX_TELEGRAM_BYTES);

   logic [1:0]    phase_ff, phase_in;
   logic [15:0]   crc_acc_ff, crc_acc_in;
   logic [CW-1:0] byte_count_ff, byte_count_in;
   logic [15:0]   crc_field_ff, crc_field_in;
   logic [2:0]    digit_count_ff, digit_count_in;

   logic [15:0]   crc_next;
   logic [4:0]    hex;
   logic [15:0]   field_next;
   logic [2:0]    digits_next;
   logic [CW-1:0] count_next;
   logic [CW+11:0] len_ext;
   logic [2:0]    digits_status;

   assign crc_next    = p1crc_pkg::crc16_update(crc_acc_ff, data_byte);
   assign hex         = p1crc_pkg::hex_decode(data_byte);
   assign field_next  = {crc_field_ff[11:0], hex[3:0]};
   assign digits_next = digit_count_ff + 3'd1;
   assign count_next  = byte_count_ff + CW'(1);
   assign len_ext     = {12'b0, byte_count_ff};

   // Status when the digit field closes (no digit added this byte)
   always_comb begin
      priority if (!check_enable) begin
         digits_status = p1crc_pkg::ST_OK;
      end else if (digit_count_ff == 3'd0) begin
         digits_status = p1crc_pkg::ST_NO_DIGITS;
      end else if (crc_acc_ff == crc_field_ff) begin
         digits_status = p1crc_pkg::ST_OK;
      end else begin
         digits_status = p1crc_pkg::ST_MISMATCH;
      end
   end

   // Next state and result
   always_comb begin
      phase_in       = phase_ff;
      crc_acc_in     = crc_acc_ff;
      byte_count_in  = byte_count_ff;
      crc_field_in   = crc_field_ff;
      digit_count_in = digit_count_ff;
      result         = '0;

      unique case (phase_ff)
         PH_HUNT: begin
            if (data_byte == p1crc_pkg::CHAR_START) begin
               crc_acc_in    = p1crc_pkg::crc16_update(16'h0000, data_byte);
               byte_count_in = CW'(1);
               phase_in      = PH_BODY;
            end
            if (burst_end) begin
               result.valid  = 1'b1;
               result.status = p1crc_pkg::ST_NONE;
            end
         end
         PH_BODY: begin
            if (byte_count_ff >= MAX_CNT) begin
               result.valid           = 1'b1;
               result.status          = p1crc_pkg::ST_TOO_LONG;
               result.computed_crc    = crc_acc_ff;
               result.telegram_length = len_ext[11:0];
            end else if (data_byte == p1crc_pkg::CHAR_END) begin
               crc_acc_in     = crc_next;
               byte_count_in  = count_next;
               crc_field_in   = 16'h0000;
               digit_count_in = 3'd0;
               phase_in       = PH_DIGITS;
               if (burst_end) begin
                  // No digits at all in this case
                  result.valid           = 1'b1;
                  result.status          = check_enable ? p1crc_pkg::ST_NO_DIGITS
                                                        : p1crc_pkg::ST_OK;
                  result.computed_crc    = crc_next;
                  result.telegram_length = 12'({12'b0, count_next});
               end
            end else begin
               crc_acc_in    = crc_next;
               byte_count_in = count_next;
               if (burst_end) begin
                  result.valid  = 1'b1;
                  result.status = p1crc_pkg::ST_NONE;
               end
            end
         end
         PH_DIGITS: begin
            result.computed_crc    = crc_acc_ff;
            result.telegram_length = len_ext[11:0];
            if (!hex[4]) begin
               result.valid        = 1'b1;
               result.status       = digits_status;
               result.received_crc = crc_field_ff;
            end else begin
               crc_field_in   = field_next;
               digit_count_in = digits_next;
               if (digits_next >= 3'd4 || burst_end) begin
                  result.valid        = 1'b1;
                  result.received_crc = field_next;
                  priority if (!check_enable) begin
                     result.status = p1crc_pkg::ST_OK;
                  end else if (crc_acc_ff == field_next) begin
                     result.status = p1crc_pkg::ST_OK;
                  end else begin
                     result.status = p1crc_pkg::ST_MISMATCH;
                  end
               end
            end
            if (!result.valid) begin
               result.computed_crc    = 16'h0000;
               result.telegram_length = 12'h000;
            end
         end
         PH_DONE: begin
            if (burst_end) begin
               phase_in = PH_HUNT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase

      // A reported status clears the work registers
      if (result.valid) begin
         crc_acc_in     = 16'h0000;
         byte_count_in  = '0;
         crc_field_in   = 16'h0000;
         digit_count_in = 3'd0;
         phase_in       = burst_end ? PH_HUNT : PH_DONE;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         crc_acc_ff     <= 16'h0000;
         byte_count_ff  <= '0;
         crc_field_ff   <= 16'h0000;
         digit_count_ff <= 3'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         crc_acc_ff     <= crc_acc_in;
         byte_count_ff  <= byte_count_in;
         crc_field_ff   <= crc_field_in;
         digit_count_ff <= digit_count_in;
      end
   end

endmodule

/* verif/tb_top.sv */
// Testbench for p1_telegram_crc_checker: directed table plus random serial bursts,
// checked against an in-bench telegram parser and CRC-16 predictor.
// Depends on rtl/p1crc_pkg.sv, rtl/p1_telegram_crc_checker.sv and rtl/p1crc_parser.sv.
`timescale 1ns / 1ps

module tb_top;

   localparam int LATENCY      = 2;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 150;
   localparam int N_DIRECTED   = 25;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] computed_crc;
      logic [15:0] received_crc;
      logic [11:0] telegram_length;
   } telegram_status_type;

   // One request byte; typed rows carry an expectation written by hand
   typedef struct packed {
      logic [7:0]          data;
      logic                last;
      logic                typed;
      telegram_status_type exp;
   } stim_row_type;

   typedef enum logic [1:0] {
      PARSE_HUNT, PARSE_BODY, PARSE_DIGITS, PARSE_DONE
   } parse_phase_type;

   typedef enum int {DIGITS_GOOD, DIGITS_BAD, DIGITS_SHORT} digit_mode_type;

   localparam logic [7:0] C_START = p1crc_pkg::CHAR_START;
   localparam logic [7:0] C_END   = p1crc_pkg::CHAR_END;

   localparam telegram_status_type NONE_EXP =
      '{p1crc_pkg::ST_NONE, 16'h0000, 16'h0000, 12'h000};
   localparam telegram_status_type NO_EXP   = '0;

   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{8'h00,   1'b1, 1'b1, NONE_EXP},  // zero byte alone in a burst
      '{8'hFF,   1'b1, 1'b1, NONE_EXP},  // all-ones byte alone
      '{C_START, 1'b1, 1'b1, NONE_EXP},  // burst ends on the start char
      '{C_START, 1'b0, 1'b0, NO_EXP},
      '{8'h00,   1'b0, 1'b0, NO_EXP},    // zero byte inside the body
      '{8'h41,   1'b1, 1'b1, NONE_EXP},  // burst ends before '!'
      '{8'h78,   1'b0, 1'b0, NO_EXP},    // noise before the start char
      '{C_START, 1'b0, 1'b0, NO_EXP},
      '{C_END,   1'b1, 1'b0, NO_EXP},    // burst ends on '!', no digits
      '{C_START, 1'b0, 1'b0, NO_EXP},
      '{C_END,   1'b0, 1'b0, NO_EXP},
      '{8'h47,   1'b0, 1'b0, NO_EXP},    // non-hex right after '!'
      '{C_START, 1'b1, 1'b0, NO_EXP},    // ignored, waits for burst end
      '{C_START, 1'b0, 1'b0, NO_EXP},
      '{8'hFF,   1'b0, 1'b0, NO_EXP},
      '{C_END,   1'b0, 1'b0, NO_EXP},
      '{8'h30,   1'b0, 1'b0, NO_EXP},    // '0'
      '{8'h66,   1'b0, 1'b0, NO_EXP},    // 'f'
      '{8'h46,   1'b0, 1'b0, NO_EXP},    // 'F'
      '{8'h39,   1'b0, 1'b0, NO_EXP},    // '9', fourth digit closes field
      '{8'h61,   1'b1, 1'b0, NO_EXP},    // trailing byte, ignored
      '{C_START, 1'b0, 1'b0, NO_EXP},
      '{C_END,   1'b0, 1'b0, NO_EXP},
      '{8'h41,   1'b0, 1'b0, NO_EXP},    // 'A'
      '{8'h62,   1'b1, 1'b0, NO_EXP}     // 'b', burst end cuts the field
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_burst_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_computed_crc;
   logic [15:0] rsp_received_crc;
   logic [11:0] rsp_telegram_length;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_check_enable;

   p1_telegram_crc_checker dut (.*);

   // Predictor state
   parse_phase_type  parse_state    = PARSE_HUNT;
   logic [15:0]      run_crc        = 16'h0000;
   int               body_count     = 0;
   logic [15:0]      digit_field    = 16'h0000;
   int               digit_count    = 0;
   bit               check_en_model = 1'b1;

   telegram_status_type awaited_status_q[$];
   stim_row_type        cur_row;
   logic [7:0]          burst_bytes[$];
   int                  error_count    = 0;
   int                  items_sent     = 0;
   int                  cycle_count    = 0;
   bit                  no_idle        = 1'b0;
   bit                  hold_request   = 1'b0;

   // Reflected CRC-16, one data bit per step
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ b[i]) begin
            c = (c >> 1) ^ p1crc_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic int hex_nibble(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h37;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h57;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) return 8'h30 + {4'h0, nib};
      return (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
   endfunction

   // Emit a status and clear the running telegram
   function automatic bit close_telegram(input logic [2:0] st, input logic [15:0] ccrc,
                                         input logic [15:0] rcrc, input logic [11:0] len,
                                         input bit last, output telegram_status_type r);
      r = '{st, ccrc, rcrc, len};
      run_crc     = 16'h0000;
      body_count  = 0;
      digit_field = 16'h0000;
      digit_count = 0;
      parse_state = last ? PARSE_HUNT : PARSE_DONE;
      return 1'b1;
   endfunction

   function automatic bit settle_digits(input bit last, output telegram_status_type r);
      logic [2:0] st;
      if (!check_en_model) begin
         st = p1crc_pkg::ST_OK;
      end else if (digit_count == 0) begin
         st = p1crc_pkg::ST_NO_DIGITS;
      end else begin
         st = (run_crc == digit_field) ? p1crc_pkg::ST_OK : p1crc_pkg::ST_MISMATCH;
      end
      return close_telegram(st, run_crc, digit_field, body_count[11:0], last, r);
   endfunction

   // Advance the parser by one byte; returns 1 when a status comes out
   function automatic bit predict_status(input logic [7:0] b, input bit last,
                                         output telegram_status_type r);
      int nib;
      r = '0;
      predict_status = 1'b0;
      case (parse_state)
         PARSE_HUNT: begin
            if (b == C_START) begin
               run_crc     = crc_step(16'h0000, b);
               body_count  = 1;
               parse_state = PARSE_BODY;
            end
            if (last) predict_status = close_telegram(p1crc_pkg::ST_NONE, 16'h0, 16'h0,
                                                      12'h0, 1'b1, r);
         end
         PARSE_BODY: begin
            if (body_count >= p1crc_pkg::MAX_TELEGRAM_BYTES) begin
               predict_status = close_telegram(p1crc_pkg::ST_TOO_LONG, run_crc, 16'h0,
                                               body_count[11:0], last, r);
            end else begin
               run_crc = crc_step(run_crc, b);
               body_count++;
               if (b == C_END) begin
                  parse_state = PARSE_DIGITS;
                  digit_field = 16'h0000;
                  digit_count = 0;
                  if (last) predict_status = settle_digits(1'b1, r);
               end else if (last) begin
                  predict_status = close_telegram(p1crc_pkg::ST_NONE, 16'h0, 16'h0,
                                                  12'h0, 1'b1, r);
               end
            end
         end
         PARSE_DIGITS: begin
            nib = hex_nibble(b);
            if (nib < 0) begin
               predict_status = settle_digits(last, r);
            end else begin
               digit_field = {digit_field[11:0], nib[3:0]};
               digit_count++;
               if (digit_count >= 4 || last) predict_status = settle_digits(last, r);
            end
         end
         default: begin
            if (last) parse_state = PARSE_HUNT;
         end
      endcase
   endfunction

   // Idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[p1_telegram_crc_checker] ERROR");
         $finish;
      end
   end

   // Result receiver: random stalls, plus one long hold-off on request
   initial begin : receiver
      int n;
      bit hold_taken;
      rsp_stall  = 1'b0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            n = pick_gap();
            rsp_stall <= (n != 0);
            if (n > 1) repeat (n - 1) @(negedge clock);
         end
      end
   end

   // Monitor: match results against predicted status, track requests and CSR writes
   always @(posedge clock) begin : monitor
      telegram_status_type got;
      telegram_status_type want;
      telegram_status_type predicted;
      bit                  produced;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_computed_crc, rsp_received_crc, rsp_telegram_length};
            if (awaited_status_q.size() == 0) begin
               $error("result with no status pending: status %0d", got.status);
               error_count++;
            end else begin
               want = awaited_status_q.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
               if (got.computed_crc !== want.computed_crc) begin
                  $error("computed_crc: expected %h, got %h",
                         want.computed_crc, got.computed_crc);
                  error_count++;
               end
               if (got.received_crc !== want.received_crc) begin
                  $error("received_crc: expected %h, got %h",
                         want.received_crc, got.received_crc);
                  error_count++;
               end
               if (got.telegram_length !== want.telegram_length) begin
                  $error("telegram_length: expected %0d, got %0d",
                         want.telegram_length, got.telegram_length);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) check_en_model = csr_check_enable;
         if (req_valid && !req_stall) begin
            produced = predict_status(req_data_byte, req_burst_end, predicted);
            if (cur_row.typed) begin
               awaited_status_q.push_back(cur_row.exp);
            end else if (produced) begin
               awaited_status_q.push_back(predicted);
            end
         end
      end
   end

   // Offer one request after a random gap and wait for it to be taken
   task automatic send_byte(input stim_row_type row);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         if (gap > 1) repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= row.data;
      req_burst_end <= row.last;
      cur_row = row;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Send the collected burst, burst_end on its final byte
   task automatic flush_burst();
      stim_row_type row;
      for (int i = 0; i < burst_bytes.size(); i++) begin
         row.data  = burst_bytes[i];
         row.last  = (i == burst_bytes.size() - 1);
         row.typed = 1'b0;
         row.exp   = NO_EXP;
         send_byte(row);
      end
      burst_bytes.delete();
   endtask

   // Well-formed telegram with noise prefix, CRC digits per mode and trailing bytes
   task automatic add_telegram(input int body_len, input digit_mode_type mode);
      logic [7:0]  b;
      logic [15:0] crc;
      logic [15:0] field;
      int          n_digits;
      repeat ($urandom_range(0, 3)) begin
         do b = 8'($urandom_range(0, 255)); while (b == C_START);
         burst_bytes.push_back(b);
      end
      burst_bytes.push_back(C_START);
      crc = crc_step(16'h0000, C_START);
      repeat (body_len) begin
         do b = 8'($urandom_range(0, 255)); while (b == C_END);
         burst_bytes.push_back(b);
         crc = crc_step(crc, b);
      end
      burst_bytes.push_back(C_END);
      crc = crc_step(crc, C_END);
      field    = crc;
      n_digits = 4;
      if (mode == DIGITS_BAD) field = 16'($urandom_range(0, 16'hFFFF));
      if (mode == DIGITS_SHORT) n_digits = $urandom_range(0, 3);
      for (int k = 0; k < n_digits; k++) begin
         burst_bytes.push_back(hex_char(field[15 - 4 * k -: 4], 1'($urandom_range(0, 1))));
      end
      // short field closed by a non-hex byte
      if (mode == DIGITS_SHORT && $urandom_range(0, 1) == 1) begin
         do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
         burst_bytes.push_back(b);
      end
      repeat ($urandom_range(0, 3)) begin
         b = 8'($urandom_range(0, 255));
         burst_bytes.push_back(b);
      end
      flush_burst();
   endtask

   // Body one byte past the limit; the overflowing byte is '!'
   task automatic add_overlong();
      logic [7:0] b;
      burst_bytes.push_back(C_START);
      repeat (p1crc_pkg::MAX_TELEGRAM_BYTES - 1) begin
         do b = 8'($urandom_range(0, 255)); while (b == C_END);
         burst_bytes.push_back(b);
      end
      burst_bytes.push_back(C_END);
      repeat ($urandom_range(0, 2)) begin
         b = 8'($urandom_range(0, 255));
         burst_bytes.push_back(b);
      end
      flush_burst();
   endtask

   task automatic add_noise_burst();
      logic [7:0] b;
      repeat ($urandom_range(1, 4)) begin
         b = 8'($urandom_range(0, 255));
         burst_bytes.push_back(b);
      end
      flush_burst();
   endtask

   task automatic add_random_burst();
      logic [7:0]     b;
      int             r;
      int             m;
      digit_mode_type mode;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         m = $urandom_range(0, 9);
         mode = (m < 6) ? DIGITS_GOOD : (m < 8) ? DIGITS_BAD : DIGITS_SHORT;
         add_telegram(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(0, 12), mode);
      end else if (r < 85) begin
         add_noise_burst();
      end else begin
         // telegram cut off before '!'
         burst_bytes.push_back(C_START);
         repeat ($urandom_range(0, 8)) begin
            do b = 8'($urandom_range(0, 255)); while (b == C_END);
            burst_bytes.push_back(b);
         end
         flush_burst();
      end
   endtask

   task automatic write_check_enable(input bit value);
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_check_enable <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid and wait until every status is back and the pipe is empty
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_status_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Main sequence
   initial begin : stimulus
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = 8'h00;
      req_burst_end    = 1'b0;
      csr_valid        = 1'b0;
      csr_check_enable = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) send_byte(DIRECTED_ROWS[i]);
      drain();

      // check_enable 0, 1, 0, 1
      for (int ph = 0; ph < 4; ph++) begin
         write_check_enable(ph % 2 == 1);
         no_idle = (ph == 1);
         if (ph == 2) begin
            // receiver holds off while short bursts keep coming
            hold_request = 1'b1;
            repeat (10) add_noise_burst();
         end
         if (ph == 3) begin
            add_telegram(p1crc_pkg::MAX_TELEGRAM_BYTES - 2, DIGITS_GOOD);
            add_overlong();
         end
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) add_random_burst();
         drain();
      end

      if (error_count == 0) begin
         $display("[p1_telegram_crc_checker] OK");
      end else begin
         $display("[p1_telegram_crc_checker] ERROR");
      end
      $finish;
   end

endmodule
